FILE: hw/rtl/rthist_pkg.sv
// Package for the response time histogram block: widths, limits and defaults.
// No dependencies.
package rthist_pkg;
  localparam int TIME_W   = 16;
  localparam int CNT_W    = 20;
  localparam int Q_W      = 20;
  localparam int HIT_W    = 16;
  localparam int OVS_W    = 40;
  localparam int DVS_W    = 21;
  localparam int NUM_HIST = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [Q_W-1:0]   Q_MAX   = {Q_W{1'b1}};

  localparam int DEF_BIN_WIDTH_MS = 20;
  localparam int DEF_BIN_COUNT    = 251;
endpackage

FILE: hw/rtl/rthist_if.sv
// Handshake channels for the response time histogram block.
// Depends on rthist_pkg.
interface rthist_in_if import rthist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] response_ms;
  logic              answered_right;
  modport source (output valid, response_ms, answered_right, input ready);
  modport sink (input valid, response_ms, answered_right, output ready);
endinterface

interface rthist_out_if import rthist_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HIT_W-1:0]  hit_fraction;
  logic [CNT_W-1:0]  presentations;
  logic [TIME_W-1:0] all_min_ms;
  logic [TIME_W-1:0] all_max_ms;
  logic [Q_W-1:0]    all_mean_q4;
  logic [Q_W-1:0]    all_dev_q4;
  logic [TIME_W-1:0] class_min_ms;
  logic [TIME_W-1:0] class_max_ms;
  logic [Q_W-1:0]    class_mean_q4;
  logic [Q_W-1:0]    class_dev_q4;
  modport source (output valid, hit_fraction, presentations, all_min_ms, all_max_ms,
                  all_mean_q4, all_dev_q4, class_min_ms, class_max_ms, class_mean_q4,
                  class_dev_q4, input ready);
  modport sink (input valid, hit_fraction, presentations, all_min_ms, all_max_ms,
                all_mean_q4, all_dev_q4, class_min_ms, class_max_ms, class_mean_q4,
                class_dev_q4, output ready);
endinterface

FILE: hw/rtl/response_time_histogram_stats.sv
// Response time histogram statistics, top level: sequencer, bin memory, shared multiplier.
// Depends on rthist_pkg, rthist_if, rthist_div, rthist_sqrt.
//
//   channel  dir  contents
//   in_ch    in   response_ms, answered_right
//   out_ch   out  hit_fraction, presentations, min/max/mean/dev for all and for the class
//
// For each item, the all and class histograms are each walked once for the mean and once
// for the deviation over BIN_COUNT-1 bins, plus up to five serial divisions and two
// square roots. The bin index is a reciprocal multiply on the shared multiplier. After
// reset a clearing pass over all DEPTH words of the bin memory runs before the first item.
// A waiting result is held in the output register; the next item may be taken meanwhile
// and stalls at its end until it is taken.
module response_time_histogram_stats import rthist_pkg::*; #(
  parameter int BIN_WIDTH_MS = DEF_BIN_WIDTH_MS,
  parameter int BIN_COUNT    = DEF_BIN_COUNT
) (
  input logic         clk,
  input logic         rst,
  rthist_in_if.sink   in_ch,
  rthist_out_if.source out_ch
);
  localparam int DEPTH  = NUM_HIST * BIN_COUNT;
  localparam int AW     = $clog2(DEPTH);
  localparam int BIW    = $clog2(BIN_COUNT);
  localparam int CW     = $clog2(BIN_WIDTH_MS * 16 * BIN_COUNT);
  localparam int DW     = (CW > Q_W) ? CW : Q_W;
  localparam int SUM_W  = (((CW + CNT_W) > (OVS_W + 4)) ? (CW + CNT_W) : (OVS_W + 4)) + 1;
  localparam int SOS_W0 = 2 * DW + CNT_W + 1;
  localparam int SOS_W  = SOS_W0 + (SOS_W0 % 2);
  localparam int NW     = (SOS_W > SUM_W) ? SOS_W : SUM_W;
  localparam int RW     = SOS_W / 2;
  localparam int RSH    = TIME_W + $clog2(BIN_WIDTH_MS);
  localparam logic [DW-1:0]  RECIP = DW'(((1 << RSH) + BIN_WIDTH_MS - 1) / BIN_WIDTH_MS);
  localparam logic [CW-1:0]  CEN0  = CW'(BIN_WIDTH_MS * 8);
  localparam logic [CW-1:0]  CSTEP = CW'(BIN_WIDTH_MS * 16);
  localparam logic [BIW-1:0] LAST  = BIW'(BIN_COUNT - 1);
  localparam logic [BIW-1:0] BLAST = BIW'(BIN_COUNT - 2);
  localparam logic [2*DW-1:0] LASTW = (2*DW)'(BIN_COUNT - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_BIN, S_UPD, S_RMW_RD, S_RMW_WR, S_HIT,
    S_P1_RD, S_P1_MUL, S_P1_ACC, S_MEAN,
    S_P2_RD, S_P2_DD, S_P2_LO, S_P2_HI, S_P2_ACC,
    S_DEV_DIV, S_DEV_SQ, S_NEXT, S_OUT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]  mem [DEPTH];
  logic [CNT_W-1:0]  mem_rdata;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic [CNT_W-1:0]  mem_wdata;
  logic [AW-1:0]     clr_addr;

  logic [CNT_W-1:0]  cnt [NUM_HIST];
  logic [OVS_W-1:0]  ovs [NUM_HIST];
  logic [TIME_W-1:0] mn [NUM_HIST];
  logic [TIME_W-1:0] mx [NUM_HIST];
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  rightc;

  logic [TIME_W-1:0] rt;
  logic              rgt;
  logic              ovf;
  logic [BIW-1:0]    idx;
  logic              ph;
  logic [1:0]        h;
  logic [BIW-1:0]    bi;
  logic [CW-1:0]     cen;
  logic [NW-1:0]     sum;
  logic [NW-1:0]     sos;
  logic [CNT_W-1:0]  m;
  logic [CNT_W-1:0]  cntr;
  logic [DW-1:0]     ddh;
  logic [2*DW-1:0]   prod;
  logic [DW-1:0]     mul_a;
  logic [DW-1:0]     mul_b;
  logic [2*DW-1:0]   binq;
  logic [DW-1:0]     d;
  logic [Q_W-1:0]    mean;
  logic [Q_W-1:0]    res_mean [2];
  logic [Q_W-1:0]    res_dev [2];
  logic [HIT_W-1:0]  hit;
  logic [AW-1:0]     base;

  logic              div_start;
  logic [NW-1:0]     dvd;
  logic [DVS_W-1:0]  dvs;
  logic              div_done;
  logic [NW-1:0]     div_q;
  logic              sq_start;
  logic [SOS_W-1:0]  sq_val;
  logic              sq_done;
  logic [RW-1:0]     sq_root;

  rthist_div #(.NW(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dvd), .divisor(dvs),
    .done(div_done), .quotient(div_q)
  );

  rthist_sqrt #(.SW(SOS_W)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_val),
    .done(sq_done), .root(sq_root)
  );

  assign h = ph ? (rgt ? 2'd1 : 2'd2) : 2'd0;

  always_comb begin
    case (h)
      2'd1:    base = AW'(BIN_COUNT);
      2'd2:    base = AW'(2 * BIN_COUNT);
      default: base = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_CLR:              mem_addr = clr_addr;
      S_RMW_RD, S_RMW_WR: mem_addr = AW'(base + AW'(idx));
      default:            mem_addr = AW'(base + AW'(bi));
    endcase
    mem_we    = (state == S_CLR) || (state == S_RMW_WR);
    mem_wdata = (state == S_CLR) ? '0 : CNT_W'(mem_rdata + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  assign d = (DW'(cen) >= DW'(mean)) ? DW'(DW'(cen) - DW'(mean)) : DW'(DW'(mean) - DW'(cen));

  always_comb begin
    case (state)
      S_BIN: begin
        mul_a = DW'(rt);
        mul_b = RECIP;
      end
      S_P2_DD: begin
        mul_a = d;
        mul_b = d;
      end
      S_P2_LO: begin
        mul_a = prod[DW-1:0];
        mul_b = DW'(cntr);
      end
      S_P2_HI: begin
        mul_a = ddh;
        mul_b = DW'(cntr);
      end
      default: begin
        mul_a = DW'(cen);
        mul_b = DW'(mem_rdata);
      end
    endcase
  end

  assign binq = (mul_a * mul_b) >> RSH;

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    div_start <= 1'b0;
    sq_start  <= 1'b0;
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      total        <= '0;
      rightc       <= '0;
      out_ch.valid <= 1'b0;
      ph           <= 1'b0;
      for (int i = 0; i < NUM_HIST; i++) begin
        cnt[i] <= '0;
        ovs[i] <= '0;
        mn[i]  <= '0;
        mx[i]  <= '0;
      end
    end else begin
      if (out_ch.ready && state != S_OUT) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            rt  <= in_ch.response_ms;
            rgt <= in_ch.answered_right;
            if (total != CNT_MAX) begin
              total  <= total + 1'b1;
              rightc <= rightc + CNT_W'(in_ch.answered_right);
            end
            state <= S_BIN;
          end
        end
        S_BIN: begin
          ovf   <= (binq >= LASTW);
          idx   <= (binq >= LASTW) ? LAST : binq[BIW-1:0];
          ph    <= 1'b0;
          state <= S_UPD;
        end
        S_UPD: begin
          if (cnt[h] == '0) begin
            mn[h] <= rt;
            mx[h] <= rt;
          end else if (rt < mn[h]) begin
            mn[h] <= rt;
          end else if (rt > mx[h]) begin
            mx[h] <= rt;
          end
          if (cnt[h] != CNT_MAX) begin
            cnt[h] <= cnt[h] + 1'b1;
            if (ovf) begin
              ovs[h] <= ovs[h] + OVS_W'(rt);
            end
            state <= S_RMW_RD;
          end else if (!ph) begin
            ph <= 1'b1;
          end else begin
            state <= S_HIT;
            dvd   <= (NW'(rightc) << 16) + NW'(total);
            dvs   <= {total, 1'b0};
            div_start <= 1'b1;
          end
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (!ph) begin
            ph    <= 1'b1;
            state <= S_UPD;
          end else begin
            state     <= S_HIT;
            dvd       <= (NW'(rightc) << 16) + NW'(total);
            dvs       <= {total, 1'b0};
            div_start <= 1'b1;
          end
        end
        S_HIT: begin
          if (div_done) begin
            hit   <= div_q[HIT_W-1:0];
            ph    <= 1'b0;
            bi    <= '0;
            cen   <= CEN0;
            sum   <= '0;
            state <= S_P1_RD;
          end
        end
        S_P1_RD: begin
          state <= S_P1_MUL;
        end
        S_P1_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_P1_ACC;
        end
        S_P1_ACC: begin
          if (bi == BLAST) begin
            dvd <= NW'(sum + NW'(prod) + (NW'(ovs[h]) << 4) + NW'(cnt[h] >> 1));
            dvs <= DVS_W'(cnt[h]);
            div_start <= 1'b1;
            state <= S_MEAN;
          end else begin
            sum   <= NW'(sum + NW'(prod));
            bi    <= bi + 1'b1;
            cen   <= cen + CSTEP;
            state <= S_P1_RD;
          end
        end
        S_MEAN: begin
          if (div_done) begin
            mean         <= (div_q > NW'(Q_MAX)) ? Q_MAX : div_q[Q_W-1:0];
            res_mean[ph] <= (div_q > NW'(Q_MAX)) ? Q_MAX : div_q[Q_W-1:0];
            bi    <= '0;
            cen   <= CEN0;
            sos   <= '0;
            m     <= '0;
            state <= S_P2_RD;
          end
        end
        S_P2_RD: begin
          state <= S_P2_DD;
        end
        S_P2_DD: begin
          prod  <= mul_a * mul_b;
          cntr  <= mem_rdata;
          m     <= m + mem_rdata;
          state <= S_P2_LO;
        end
        S_P2_LO: begin
          ddh   <= prod[2*DW-1:DW];
          prod  <= mul_a * mul_b;
          state <= S_P2_HI;
        end
        S_P2_HI: begin
          sos   <= NW'(sos + NW'(prod));
          prod  <= mul_a * mul_b;
          state <= S_P2_ACC;
        end
        S_P2_ACC: begin
          if (bi == BLAST) begin
            if (m == '0) begin
              res_dev[ph] <= '0;
              state       <= S_NEXT;
            end else begin
              dvd       <= NW'(sos + (NW'(prod) << DW));
              dvs       <= DVS_W'(m);
              div_start <= 1'b1;
              state     <= S_DEV_DIV;
            end
          end else begin
            sos   <= NW'(sos + (NW'(prod) << DW));
            bi    <= bi + 1'b1;
            cen   <= cen + CSTEP;
            state <= S_P2_RD;
          end
        end
        S_DEV_DIV: begin
          if (div_done) begin
            sq_val   <= div_q[SOS_W-1:0];
            sq_start <= 1'b1;
            state    <= S_DEV_SQ;
          end
        end
        S_DEV_SQ: begin
          if (sq_done) begin
            res_dev[ph] <= (sq_root > RW'(Q_MAX)) ? Q_MAX : sq_root[Q_W-1:0];
            state       <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (!ph) begin
            ph    <= 1'b1;
            bi    <= '0;
            cen   <= CEN0;
            sum   <= '0;
            state <= S_P1_RD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid         <= 1'b1;
            out_ch.hit_fraction  <= hit;
            out_ch.presentations <= total;
            out_ch.all_min_ms    <= mn[0];
            out_ch.all_max_ms    <= mx[0];
            out_ch.all_mean_q4   <= res_mean[0];
            out_ch.all_dev_q4    <= res_dev[0];
            out_ch.class_min_ms  <= mn[h];
            out_ch.class_max_ms  <= mx[h];
            out_ch.class_mean_q4 <= res_mean[1];
            out_ch.class_dev_q4  <= res_dev[1];
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hw/rtl/rthist_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on rthist_pkg.
module rthist_div import rthist_pkg::*; #(
  parameter int NW = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NW-1:0]    dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [NW-1:0]    quotient
);
  localparam int KW = $clog2(NW + 1);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [KW-1:0]    k;
  logic             busy;
  logic [DVS_W:0]   tr;

  assign tr = {rem, quotient[NW-1]};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (start) begin
      quotient <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      k        <= KW'(NW);
      busy     <= 1'b1;
    end else if (busy) begin
      if (tr >= {1'b0, dvs}) begin
        rem      <= DVS_W'(tr - {1'b0, dvs});
        quotient <= {quotient[NW-2:0], 1'b1};
      end else begin
        rem      <= tr[DVS_W-1:0];
        quotient <= {quotient[NW-2:0], 1'b0};
      end
      k <= k - 1'b1;
      if (k == KW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/rthist_sqrt.sv
// Integer square root, one root bit per cycle (floor).
// Depends on rthist_pkg.
module rthist_sqrt import rthist_pkg::*; #(
  parameter int SW = 80
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SW-1:0]   value,
  output logic            done,
  output logic [SW/2-1:0] root
);
  localparam int RW = SW / 2;
  localparam int KW = $clog2(RW + 1);

  logic [SW-1:0]   v;
  logic [RW+1:0]   rem;
  logic [KW-1:0]   k;
  logic            busy;
  logic [RW+3:0]   r2;
  logic [RW+3:0]   trial;

  assign r2    = {rem, v[SW-1:SW-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      k    <= '0;
    end else if (start) begin
      v    <= value;
      rem  <= '0;
      root <= '0;
      k    <= KW'(RW);
      busy <= 1'b1;
    end else if (busy) begin
      if (r2 >= trial) begin
        rem  <= (RW+2)'(r2 - trial);
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= r2[RW+1:0];
        root <= {root[RW-2:0], 1'b0};
      end
      v <= {v[SW-3:0], 2'b00};
      k <= k - 1'b1;
      if (k == KW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
